>>> src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants for the buddy page allocator: fixed field widths of the
// request and result words.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int ADDR_W  = 16;   // block_address / granted_address width
    localparam int ORDER_W = 4;    // block_order width

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

>>> src/bpa_link_ram.sv
// ----------------------------------------------------------------------------
// bpa_link_ram
// Per-page next-link store: one write port, one read port, registered read
// data.
// ----------------------------------------------------------------------------
module bpa_link_ram #(
    parameter int PAGE_INDEX_BITS = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [PAGE_INDEX_BITS-1:0] wr_addr,
    input  logic [PAGE_INDEX_BITS:0]   wr_data,
    input  logic [PAGE_INDEX_BITS-1:0] rd_addr,
    output logic [PAGE_INDEX_BITS:0]   rd_data
);

    localparam int DEPTH = 1 << PAGE_INDEX_BITS;

    logic [PAGE_INDEX_BITS:0] mem [DEPTH];
    logic [PAGE_INDEX_BITS:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over 2^PAGE_INDEX_BITS pages with one LIFO free list per
// order, linked through a single-port-write, single-port-read link memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall): mode, block_order, block_address.
//   A word is taken when in_valid is high and in_stall is low.
//   Result channel (out_valid/out_stall): success, granted_address, one
//   result word per request, held steady while out_stall is high.
// Sequencing (one request at a time; in_stall stays high until the result
//   word is loaded into the output register):
//   allocate: scan the orders upward for a non-empty list, pop its head,
//             then split down to the requested order, pushing upper halves.
//   free: per order level, walk the list for the buddy and merge one order
//         up on a match, else push the block; a long list walk dominates.
// Reset: after rst_n releases, an init pass writes the chain of the
//   TOP_BLOCK_COUNT top blocks into the link memory, one per cycle,
//   with in_stall high throughout.
// Stall: a finished result waits in the output register; the next request
//   is still accepted, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int ORDER_COUNT     = 11,
    parameter int TOP_BLOCK_COUNT = 64,
    parameter int PAGE_INDEX_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [bpa_pkg::ORDER_W-1:0]  block_order,
    input  logic [bpa_pkg::ADDR_W-1:0]   block_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         success,
    output logic [bpa_pkg::ADDR_W-1:0]   granted_address
);

    localparam int PW        = PAGE_INDEX_BITS;
    localparam int OW        = $clog2(ORDER_COUNT + 1);
    localparam int OIW       = $clog2(ORDER_COUNT);
    localparam int IW        = $clog2(TOP_BLOCK_COUNT + 1);
    localparam int TOP_ORDER = ORDER_COUNT - 1;
    localparam logic [PW:0] END_MARK = (PW + 1)'(1) << PW;
    localparam logic [PW:0] WALK_MAX = (PW + 1)'(1) << PW;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_SCAN,
        S_A_POP,
        S_A_SPLIT,
        S_F_START,
        S_F_CHECK,
        S_F_NEXT,
        S_DONE
    } state_t;

    state_t        state_reg;
    logic [IW-1:0] init_cnt_reg;
    logic [OW-1:0] req_order_reg;
    logic [OW-1:0] ord_reg;
    logic [PW-1:0] page_reg;
    logic [PW:0]   cur_reg;
    logic [PW:0]   prev_reg;
    logic [PW:0]   steps_reg;
    logic          pair_reg;
    logic          res_ok_reg;
    logic [PW-1:0] res_page_reg;
    logic          out_valid_reg;
    logic          success_reg;
    logic [bpa_pkg::ADDR_W-1:0] granted_reg;

    logic [PW:0]   head_reg [ORDER_COUNT];
    logic [15:0]   cnt_reg  [ORDER_COUNT];

    // memory port
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW:0]   wr_data;
    logic [PW-1:0] rd_addr;
    logic [PW:0]   rd_data;

    // helpers
    logic [OIW-1:0] oi;
    logic [OIW-1:0] oi_m1;
    logic [OW-1:0]  ord_m1;
    logic [PW:0]    head_cur;
    logic [PW-1:0]  split_addr;
    logic [PW-1:0]  init_addr;
    logic [PW:0]    init_link;
    logic [PW:0]    half;
    logic [PW:0]    span_mask;
    logic [PW:0]    p_ext;
    logic [PW:0]    q_ext;
    logic           is_pair;
    logic           walk_end;
    logic           order_ok;

    assign ord_m1   = ord_reg - OW'(1);
    assign oi       = ord_reg[OIW-1:0];
    assign oi_m1    = ord_m1[OIW-1:0];
    assign head_cur = head_reg[oi];
    assign order_ok = ({1'b0, block_order} < (bpa_pkg::ORDER_W + 1)'(ORDER_COUNT));

    // split half address and init chain words
    assign split_addr = page_reg + (PW'(1) << ord_m1);
    assign init_addr  = PW'(32'(init_cnt_reg) << TOP_ORDER);
    assign init_link  = (32'(init_cnt_reg) + 1 < TOP_BLOCK_COUNT)
                      ? {1'b0, PW'((32'(init_cnt_reg) + 1) << TOP_ORDER)} : END_MARK;

    // buddy test of page_reg against the current list entry
    always_comb
    begin
        half      = (PW + 1)'(1) << ord_reg;
        span_mask = (half << 1) - (PW + 1)'(1);
        p_ext     = {1'b0, page_reg};
        q_ext     = {1'b0, cur_reg[PW-1:0]};
        if (p_ext < q_ext)
        begin
            is_pair = ((p_ext & span_mask) == '0) && (p_ext + half == q_ext);
        end
        else
        begin
            is_pair = ((q_ext & span_mask) == '0) && (p_ext - q_ext == half);
        end
    end

    assign walk_end = (cur_reg == END_MARK) || (steps_reg == WALK_MAX);

    // link memory control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = page_reg;
        wr_data = head_cur;
        rd_addr = cur_reg[PW-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = init_addr;
                wr_data = init_link;
            end
            S_A_SCAN:
            begin
                rd_addr = head_cur[PW-1:0];
            end
            S_A_SPLIT:
            begin
                wr_en   = (ord_reg > req_order_reg);
                wr_addr = split_addr;
                wr_data = head_reg[oi_m1];
            end
            S_F_START:
            begin
                wr_en   = (ord_reg >= OW'(TOP_ORDER));
                wr_addr = page_reg;
                wr_data = head_reg[TOP_ORDER];
            end
            S_F_CHECK:
            begin
                wr_en   = walk_end;
                wr_addr = page_reg;
                wr_data = head_cur;
            end
            S_F_NEXT:
            begin
                wr_en   = pair_reg && (prev_reg != END_MARK);
                wr_addr = prev_reg[PW-1:0];
                wr_data = rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    bpa_link_ram #(
        .PAGE_INDEX_BITS(PAGE_INDEX_BITS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state machine, list heads, counts and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                head_reg[i] <= (i == TOP_ORDER) ? '0 : END_MARK;
                cnt_reg[i]  <= (i == TOP_ORDER) ? 16'(TOP_BLOCK_COUNT) : 16'd0;
            end
        end
        else
        begin
            // drop the result word once taken, unless a new one loads now
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + IW'(1);
                    if (32'(init_cnt_reg) + 1 >= TOP_BLOCK_COUNT)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_order_reg <= OW'(block_order);
                        ord_reg       <= OW'(block_order);
                        page_reg      <= PW'(block_address);
                        if (!order_ok)
                        begin
                            res_ok_reg   <= 1'b0;
                            res_page_reg <= '0;
                            state_reg    <= S_DONE;
                        end
                        else if (mode == bpa_pkg::MODE_ALLOC)
                        begin
                            state_reg <= S_A_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_F_START;
                        end
                    end
                end
                S_A_SCAN:
                begin
                    if (ord_reg == OW'(ORDER_COUNT))
                    begin
                        res_ok_reg   <= 1'b0;
                        res_page_reg <= '0;
                        state_reg    <= S_DONE;
                    end
                    else if (head_cur != END_MARK)
                    begin
                        page_reg  <= head_cur[PW-1:0];
                        state_reg <= S_A_POP;
                    end
                    else
                    begin
                        ord_reg <= ord_reg + OW'(1);
                    end
                end
                S_A_POP:
                begin
                    head_reg[oi] <= rd_data;
                    cnt_reg[oi]  <= cnt_reg[oi] - 16'd1;
                    state_reg    <= S_A_SPLIT;
                end
                S_A_SPLIT:
                begin
                    // push upper halves down to the requested order
                    if (ord_reg > req_order_reg)
                    begin
                        head_reg[oi_m1] <= {1'b0, split_addr};
                        cnt_reg[oi_m1]  <= cnt_reg[oi_m1] + 16'd1;
                        ord_reg         <= ord_m1;
                    end
                    else
                    begin
                        res_ok_reg   <= 1'b1;
                        res_page_reg <= page_reg;
                        state_reg    <= S_DONE;
                    end
                end
                S_F_START:
                begin
                    if (ord_reg >= OW'(TOP_ORDER))
                    begin
                        head_reg[TOP_ORDER] <= {1'b0, page_reg};
                        cnt_reg[TOP_ORDER]  <= cnt_reg[TOP_ORDER] + 16'd1;
                        res_ok_reg          <= 1'b1;
                        res_page_reg        <= '0;
                        state_reg           <= S_DONE;
                    end
                    else
                    begin
                        prev_reg  <= END_MARK;
                        cur_reg   <= head_cur;
                        steps_reg <= '0;
                        state_reg <= S_F_CHECK;
                    end
                end
                S_F_CHECK:
                begin
                    if (walk_end)
                    begin
                        // no buddy: push the block on this order
                        head_reg[oi] <= {1'b0, page_reg};
                        cnt_reg[oi]  <= cnt_reg[oi] + 16'd1;
                        res_ok_reg   <= 1'b1;
                        res_page_reg <= '0;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        pair_reg  <= is_pair;
                        state_reg <= S_F_NEXT;
                    end
                end
                S_F_NEXT:
                begin
                    if (pair_reg)
                    begin
                        // unlink the buddy and merge one order up
                        if (prev_reg == END_MARK)
                        begin
                            head_reg[oi] <= rd_data;
                        end
                        cnt_reg[oi] <= cnt_reg[oi] - 16'd1;
                        if (page_reg > cur_reg[PW-1:0])
                        begin
                            page_reg <= cur_reg[PW-1:0];
                        end
                        ord_reg   <= ord_reg + OW'(1);
                        state_reg <= S_F_START;
                    end
                    else
                    begin
                        prev_reg  <= {1'b0, cur_reg[PW-1:0]};
                        cur_reg   <= rd_data;
                        steps_reg <= steps_reg + (PW + 1)'(1);
                        state_reg <= S_F_CHECK;
                    end
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        success_reg   <= res_ok_reg;
                        granted_reg   <= bpa_pkg::ADDR_W'(res_page_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign success         = success_reg;
    assign granted_address = granted_reg;

endmodule
